FILE: rtl/cmh_pkg.sv
// ---------------------------------------------------------------------------
// cmh_pkg: shared types and constants for the calibrated compass heading unit
// Widths, CORDIC step count, arctangent table and the queue entry format.
// ---------------------------------------------------------------------------
package cmh_pkg;

	// CORDIC iteration count (12..32)
	localparam int CORDIC_STEPS = 20;
	localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// datapath widths
	localparam int SAMPLE_W = 16;   // raw axis sample
	localparam int DIFF_W   = 18;   // recentred sample
	localparam int SPAN_W   = 17;   // max - min
	localparam int PROD_W   = 36;   // cross-scaled vector component
	localparam int ZW       = 26;   // angle accumulator, signed Q.16 degrees
	localparam int HEAD_W   = 9;    // whole-degree heading

	// angle constants in Q.16 degrees
	localparam logic signed [ZW-1:0] DEG_HALF    = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] DEG_QUARTER = ZW'(90 * 65536);
	localparam logic [HEAD_W:0]      FULL_TURN   = (HEAD_W + 1)'(360);

	// item classification produced by the front end
	localparam logic [1:0] KIND_CLEAR = 2'd0;   // bounds cleared, empty result
	localparam logic [1:0] KIND_WAIT  = 2'd1;   // a span still zero, empty result
	localparam logic [1:0] KIND_CALC  = 2'd2;   // heading to be computed

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [SPAN_W-1:0]        span_x;
		logic [SPAN_W-1:0]        span_y;
	} cmh_entry_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(2949120);
			5'd1:    v = ZW'(1740967);
			5'd2:    v = ZW'(919879);
			5'd3:    v = ZW'(466945);
			5'd4:    v = ZW'(234379);
			5'd5:    v = ZW'(117304);
			5'd6:    v = ZW'(58666);
			5'd7:    v = ZW'(29335);
			5'd8:    v = ZW'(14668);
			5'd9:    v = ZW'(7334);
			5'd10:   v = ZW'(3667);
			5'd11:   v = ZW'(1833);
			5'd12:   v = ZW'(917);
			5'd13:   v = ZW'(458);
			5'd14:   v = ZW'(229);
			5'd15:   v = ZW'(115);
			5'd16:   v = ZW'(57);
			5'd17:   v = ZW'(29);
			5'd18:   v = ZW'(14);
			5'd19:   v = ZW'(7);
			5'd20:   v = ZW'(4);
			5'd21:   v = ZW'(2);
			5'd22:   v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/compass_heading_min_max_calibrated_unit.sv
// ---------------------------------------------------------------------------
// compass_heading_min_max_calibrated_unit: calibrated two-axis compass heading
// Clear/not-ready items, and items whose recentred X or Y is zero, bypass the rotator.
// The shared CORDIC rotator takes a new heading only after the previous one is done.
// Reset: asynchronous, clears calibration bounds, queue, sequencer and output valid.
// ---------------------------------------------------------------------------
module compass_heading_min_max_calibrated_unit import cmh_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic signed [SAMPLE_W-1:0] x_sample,
	input  logic signed [SAMPLE_W-1:0] y_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [HEAD_W-1:0]          heading_deg,
	output logic                       ready_res
);

	logic       push, pop, q_full, q_empty;
	cmh_entry_t push_entry, pop_entry;

	assign in_stall = q_full;

	// front end: bounds and classification
	cmh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.q_full   (q_full),
		.mode     (mode),
		.x_sample (x_sample),
		.y_sample (y_sample),
		.push     (push),
		.entry    (push_entry)
	);

	// decoupling queue
	cmh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	// back end: scaling, CORDIC, result transaction
	cmh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_entry     (pop_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heading_deg (heading_deg),
		.ready_res   (ready_res)
	);

endmodule

FILE: rtl/cmh_front.sv
// ---------------------------------------------------------------------------
// cmh_front: calibration bounds and item classification
// Widens the running min/max per axis (or clears them on a clear item), recentres
// the sample and emits a classified entry toward the queue.
// ---------------------------------------------------------------------------
module cmh_front import cmh_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       q_full,
	input  logic                       mode,
	input  logic signed [SAMPLE_W-1:0] x_sample,
	input  logic signed [SAMPLE_W-1:0] y_sample,
	output logic                       push,
	output cmh_entry_t                 entry
);

	logic signed [SAMPLE_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [SAMPLE_W-1:0] nx_min, nx_max, ny_min, ny_max;
	logic signed [SAMPLE_W:0]   sum_x, sum_y, mean_x, mean_y;
	logic                       spans_ok;

	assign push = in_valid && !q_full;

	// widened bounds
	assign nx_min = (x_sample < x_min_q) ? x_sample : x_min_q;
	assign nx_max = (x_sample > x_max_q) ? x_sample : x_max_q;
	assign ny_min = (y_sample < y_min_q) ? y_sample : y_min_q;
	assign ny_max = (y_sample > y_max_q) ? y_sample : y_max_q;

	assign spans_ok = (nx_min != nx_max) && (ny_min != ny_max);

	// mean of bounds, truncated toward zero
	assign sum_x  = (SAMPLE_W + 1)'(nx_max) + (SAMPLE_W + 1)'(nx_min);
	assign sum_y  = (SAMPLE_W + 1)'(ny_max) + (SAMPLE_W + 1)'(ny_min);
	assign mean_x = (sum_x + $signed({{SAMPLE_W{1'b0}}, sum_x[SAMPLE_W]})) >>> 1;
	assign mean_y = (sum_y + $signed({{SAMPLE_W{1'b0}}, sum_y[SAMPLE_W]})) >>> 1;

	// entry toward the back end
	always_comb begin
		entry.dx     = DIFF_W'(x_sample) - DIFF_W'(mean_x);
		entry.dy     = DIFF_W'(y_sample) - DIFF_W'(mean_y);
		entry.span_x = SPAN_W'(nx_max) - SPAN_W'(nx_min);
		entry.span_y = SPAN_W'(ny_max) - SPAN_W'(ny_min);
		if (mode)
			entry.kind = KIND_CLEAR;
		else if (spans_ok)
			entry.kind = KIND_CALC;
		else
			entry.kind = KIND_WAIT;
	end

	// bounds registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (push) begin
			if (mode) begin
				x_min_q <= '0;
				x_max_q <= '0;
				y_min_q <= '0;
				y_max_q <= '0;
			end else begin
				x_min_q <= nx_min;
				x_max_q <= nx_max;
				y_min_q <= ny_min;
				y_max_q <= ny_max;
			end
		end
	end

endmodule

FILE: rtl/cmh_queue.sv
// ---------------------------------------------------------------------------
// cmh_queue: short entry queue between front and back
// Small circular buffer; front pushes when not full, back pops when not empty.
// ---------------------------------------------------------------------------
module cmh_queue import cmh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmh_entry_t push_entry,
	input  logic       pop,
	output cmh_entry_t pop_entry,
	output logic       full,
	output logic       empty
);

	cmh_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/cmh_back.sv
// ---------------------------------------------------------------------------
// cmh_back: cross-scaling, iterative CORDIC and heading output register
// Pops one entry; for a heading item it scales the vector and, unless an axis is
// zero, rotates it one step per cycle; then drives the result transaction.
// ---------------------------------------------------------------------------
module cmh_back import cmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmh_entry_t        q_entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HEAD_W-1:0] heading_deg,
	output logic              ready_res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PRE  = 3'd2;
	localparam logic [2:0] ST_ROT  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]               state_q;
	logic                     calc_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [SPAN_W-1:0]        span_x_q, span_y_q;
	logic signed [PROD_W-1:0] vx_q, vy_q, prod_x, prod_y, sx, sy;
	logic signed [ZW-1:0]     z_q, z_clamp, z_mag;
	logic [ITER_W-1:0]        cnt_q;
	logic [HEAD_W:0]          whole, head_full;
	logic                     out_free;
	logic                     out_valid_q;
	logic [HEAD_W-1:0]        heading_q;
	logic                     ready_q;

	assign out_valid   = out_valid_q;
	assign heading_deg = heading_q;
	assign ready_res   = ready_q;
	assign out_free    = !out_valid_q || !out_stall;
	assign pop         = (state_q == ST_IDLE) && !q_empty;

	// cross-scaled vector: (dx * span_y, dy * span_x)
	assign prod_x = dx_q * $signed({1'b0, span_y_q});
	assign prod_y = dy_q * $signed({1'b0, span_x_q});

	// CORDIC shifted terms
	assign sx = vx_q >>> cnt_q;
	assign sy = vy_q >>> cnt_q;

	// clamp, truncate toward zero, fold into 1..360
	always_comb begin
		if (z_q > DEG_HALF)
			z_clamp = DEG_HALF;
		else if (z_q < -DEG_HALF)
			z_clamp = -DEG_HALF;
		else
			z_clamp = z_q;
		z_mag = z_clamp[ZW-1] ? -z_clamp : z_clamp;
		whole = z_mag[ZW-1:16];
		if (z_clamp[ZW-1] || whole == '0)
			head_full = FULL_TURN - whole;
		else
			head_full = whole;
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			calc_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						calc_q  <= (q_entry.kind == KIND_CALC);
						state_q <= (q_entry.kind == KIND_CALC) ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					state_q <= ST_PRE;
				end
				ST_PRE: begin
					cnt_q <= '0;
					if (vy_q == '0 || vx_q == '0)
						state_q <= ST_FIN;
					else
						state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_W'(CORDIC_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the rotator
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dx_q     <= q_entry.dx;
				dy_q     <= q_entry.dy;
				span_x_q <= q_entry.span_x;
				span_y_q <= q_entry.span_y;
			end
			ST_MUL: begin
				vx_q <= prod_x;
				vy_q <= prod_y;
			end
			ST_PRE: begin
				if (vy_q == '0) begin
					z_q <= vx_q[PROD_W-1] ? DEG_HALF : '0;
				end else if (vx_q == '0) begin
					z_q <= vy_q[PROD_W-1] ? -DEG_QUARTER : DEG_QUARTER;
				end else if (vx_q[PROD_W-1]) begin
					// left half plane: rotate by a half turn first
					z_q  <= vy_q[PROD_W-1] ? -DEG_HALF : DEG_HALF;
					vx_q <= -vx_q;
					vy_q <= -vy_q;
				end else begin
					z_q <= '0;
				end
			end
			ST_ROT: begin
				if (vy_q > 0) begin
					vx_q <= vx_q + sy;
					vy_q <= vy_q - sx;
					z_q  <= z_q + atan_q16(5'(cnt_q));
				end else begin
					vx_q <= vx_q - sy;
					vy_q <= vy_q + sx;
					z_q  <= z_q - atan_q16(5'(cnt_q));
				end
			end
			default: begin
			end
		endcase
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			heading_q <= calc_q ? head_full[HEAD_W-1:0] : '0;
			ready_q   <= calc_q;
		end
	end

endmodule

FILE: sim/tb_compass_heading_min_max_calibrated_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_compass_heading_min_max_calibrated_unit: self-checking bench
// Drives heading samples and clear transactions through the valid/stall
// input and checks every heading and ready flag against an in-bench model
// of the min/max calibration and the CORDIC angle. Both sides idle at
// random; the output side also holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_compass_heading_min_max_calibrated_unit;
	import cmh_pkg::*;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * (CORDIC_STEPS + 5);
	localparam int HOLD_CYCLES  = 300;

	localparam longint Q16_ONE       = 65536;
	localparam longint HALF_TURN_Q16 = 180 * Q16_ONE;
	localparam int     ANGLE_STEPS   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	localparam longint ATAN_STEP_Q16 [32] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0
	};

	typedef struct {
		logic [HEAD_W-1:0] deg;
		logic              rdy;
	} heading_t;

	// calibration bounds, expected headings and the comparison
	class heading_checker;
		int       x_lo, x_hi, y_lo, y_hi;
		heading_t headings_due[$];
		int       errors;

		function new();
			clear_bounds();
			errors = 0;
		endfunction

		function void clear_bounds();
			x_lo = 0;
			x_hi = 0;
			y_lo = 0;
			y_hi = 0;
		endfunction

		function int x_centre();
			return (x_hi + x_lo) / 2;
		endfunction

		function int y_centre();
			return (y_hi + y_lo) / 2;
		endfunction

		function int pending();
			return headings_due.size();
		endfunction

		// vectoring CORDIC, result in Q.16 degrees within +/-180
		function longint angle_q16(input longint vx, input longint vy);
			longint z;
			longint tx, ty;
			z = 0;
			if (vy == 0)
				return (vx < 0) ? HALF_TURN_Q16 : 0;
			if (vx == 0)
				return (vy > 0) ? 90 * Q16_ONE : -90 * Q16_ONE;
			if (vx < 0) begin
				z  = (vy >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
				vx = -vx;
				vy = -vy;
			end
			for (int i = 0; i < ANGLE_STEPS; i++) begin
				tx = vx >>> i;
				ty = vy >>> i;
				if (vy > 0) begin
					vx = vx + ty;
					vy = vy - tx;
					z += ATAN_STEP_Q16[i];
				end else begin
					vx = vx - ty;
					vy = vy + tx;
					z -= ATAN_STEP_Q16[i];
				end
			end
			if (z > HALF_TURN_Q16)
				z = HALF_TURN_Q16;
			if (z < -HALF_TURN_Q16)
				z = -HALF_TURN_Q16;
			return z;
		endfunction

		// accepted input transaction: update bounds, queue the heading
		function void note_sample(input logic m, input logic signed [SAMPLE_W-1:0] xs,
				input logic signed [SAMPLE_W-1:0] ys);
			heading_t r;
			int x, y, dx, dy, span_x, span_y;
			longint z, d;
			r.deg = '0;
			r.rdy = 1'b0;
			if (m == MODE_CLEAR) begin
				clear_bounds();
			end else begin
				x = xs;
				y = ys;
				if (x < x_lo) x_lo = x;
				if (x > x_hi) x_hi = x;
				if (y < y_lo) y_lo = y;
				if (y > y_hi) y_hi = y;
				if (x_lo != x_hi && y_lo != y_hi) begin
					dx     = x - x_centre();
					dy     = y - y_centre();
					span_x = x_hi - x_lo;
					span_y = y_hi - y_lo;
					z = angle_q16(longint'(dx) * span_y, longint'(dy) * span_x);
					d = (z >= 0) ? (z >>> 16) : -((-z) >>> 16);
					if (d <= 0)
						d += 360;
					r.deg = d[HEAD_W-1:0];
					r.rdy = 1'b1;
				end
			end
			headings_due.push_back(r);
		endfunction

		function void fail_note(input string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// accepted output transaction against the oldest expectation
		function void check_heading(input logic [HEAD_W-1:0] deg, input logic rdy);
			heading_t e;
			if (headings_due.size() == 0) begin
				fail_note($sformatf("unexpected result heading=%0d ready=%b", deg, rdy));
				return;
			end
			e = headings_due.pop_front();
			if (deg !== e.deg)
				fail_note($sformatf("heading_deg exp %0d got %0d", e.deg, deg));
			if (rdy !== e.rdy)
				fail_note($sformatf("ready_res exp %b got %b", e.rdy, rdy));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] x_sample;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [HEAD_W-1:0]          heading_deg;
	logic                       ready_res;

	heading_checker chk = new();
	bit             hold_req = 0;
	int             burst_left = 0;
	int             cycles = 0;

	// random sweep state: box centre and half width
	int session_left = 0;
	int box_cx, box_cy, box_r;

	compass_heading_min_max_calibrated_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.heading_deg(heading_deg),
		.ready_res  (ready_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// output side: stall phases, plus one long hold-off on request
	initial begin
		int phase_left;
		int stall_pct;
		phase_left = 0;
		stall_pct  = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(1, 50);
					case ($urandom_range(0, 4))
						0: stall_pct = 0;
						1: stall_pct = 10;
						2: stall_pct = 40;
						3: stall_pct = 80;
						default: begin
							stall_pct  = 100;
							phase_left = $urandom_range(1, 6);
						end
					endcase
				end
				phase_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// result check, sampled away from the active edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			chk.check_heading(heading_deg, ready_res);
	end

	// one input transaction; called and returns at a rising edge
	task automatic send_item(input logic m, input int xv, input int yv);
		bit taken;
		in_valid <= 1'b1;
		mode     <= m;
		x_sample <= SAMPLE_W'(xv);
		y_sample <= SAMPLE_W'(yv);
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		chk.note_sample(m, SAMPLE_W'(xv), SAMPLE_W'(yv));
	endtask

	// bursts of back-to-back transactions separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0)
			@(posedge clk);
	endtask

	function automatic int clamp16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int box_point(input int c);
		return clamp16(c + $urandom_range(0, 2 * box_r) - box_r);
	endfunction

	function automatic int any16();
		return $signed(16'($urandom));
	endfunction

	// random transaction: calibration sweeps in a box, with noise and stray clears
	task automatic random_item();
		int pick, xv, yv;
		if (session_left == 0) begin
			session_left = $urandom_range(5, 60);
			case ($urandom_range(0, 3))
				0: box_r = $urandom_range(1, 8);
				1: box_r = $urandom_range(1, 500);
				2: box_r = $urandom_range(1, 8000);
				default: box_r = 32768;
			endcase
			box_cx = (box_r == 32768) ? 0 : any16();
			box_cy = (box_r == 32768) ? 0 : any16();
			if ($urandom_range(0, 1) == 1) begin
				send_item(MODE_CLEAR, any16(), any16());
				return;
			end
		end
		session_left--;
		pick = $urandom_range(0, 99);
		xv = box_point(box_cx);
		yv = box_point(box_cy);
		if (pick < 5) begin
			xv = any16();
			yv = any16();
		end else if (pick < 12) begin
			xv = chk.x_centre();
		end else if (pick < 19) begin
			yv = chk.y_centre();
		end else if (pick < 22) begin
			xv = chk.x_centre();
			yv = chk.y_centre();
		end else if (pick < 24) begin
			send_item(MODE_CLEAR, xv, yv);
			return;
		end
		send_item(MODE_SAMPLE, xv, yv);
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_SAMPLE;
		x_sample = '0;
		y_sample = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: clear, not ready, exact axes, zero vector, extremes
		send_item(MODE_CLEAR, 32767, -32768);
		send_item(MODE_SAMPLE, 0, 0);
		send_item(MODE_SAMPLE, 100, 0);
		send_item(MODE_SAMPLE, -100, 100);
		send_item(MODE_SAMPLE, 0, -100);
		send_item(MODE_SAMPLE, 0, 0);
		send_item(MODE_SAMPLE, 0, 50);
		send_item(MODE_SAMPLE, 50, 0);
		send_item(MODE_SAMPLE, -50, 0);
		send_item(MODE_SAMPLE, 37, -81);
		send_item(MODE_SAMPLE, 32767, 32767);
		send_item(MODE_SAMPLE, -32768, -32768);
		send_item(MODE_SAMPLE, -32768, 32767);
		send_item(MODE_SAMPLE, 32767, -32768);
		send_item(MODE_SAMPLE, 0, 0);
		send_item(MODE_CLEAR, -32768, 32767);
		send_item(MODE_SAMPLE, -32768, -32768);
		send_item(MODE_SAMPLE, 32767, 32767);
		send_item(MODE_SAMPLE, -1, 1);
		// odd bound sums: centre truncates toward zero
		send_item(MODE_CLEAR, 0, 0);
		send_item(MODE_SAMPLE, -3, -3);
		send_item(MODE_SAMPLE, -1, -2);
		send_item(MODE_SAMPLE, -2, -1);
		send_item(MODE_SAMPLE, -3, 0);

		// random phase
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400)
				hold_req = 1;
			if (n == 900)
				wait_drained();
			random_item();
			pace();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
